// ===== design/alarm_table_scheduler_assert.svh =====
// Assertion macros for the alarm table scheduler.
`ifndef ALARM_TABLE_SCHEDULER_ASSERT_SVH
`define ALARM_TABLE_SCHEDULER_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define ATS_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alarm table scheduler check failed");
// Check a condition in the cycle after its trigger.
`define ATS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alarm table scheduler check failed");
`endif

// ===== design/ats_pkg.sv =====
// Types and codes shared by the alarm table scheduler.
package ats_pkg;
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_SET_ONE = 3'd1;
    localparam logic [2:0] OP_SET_PER = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_TICK = 3'd4;
    localparam logic [2:0] OP_STATS = 3'd5;
    localparam logic [2:0] OP_QUERY = 3'd6;

    localparam logic [2:0] K_FIRED = 3'd0;
    localparam logic [2:0] K_TICK_IDLE = 3'd1;
    localparam logic [2:0] K_ACCEPTED = 3'd2;
    localparam logic [2:0] K_FULL = 3'd3;
    localparam logic [2:0] K_STATS = 3'd4;
    localparam logic [2:0] K_FOUND = 3'd5;
    localparam logic [2:0] K_NONE = 3'd6;

    localparam int ACW = 7;
    localparam int NW = 6;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] handle;
        logic [31:0] handler_id;
        logic [63:0] amount;
        logic [62:0] repeat_period;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] fired_handle;
        logic [31:0] fired_handler;
        logic [63:0] lateness;
        logic [63:0] deadline;
        logic [4:0]  active_count;
        logic [31:0] fire_total;
        logic        last;
    } t_res;
endpackage

// ===== design/alarm_table_scheduler.sv =====
// Alarm table scheduler: slot table in one memory with a read-modify-write sequencer.
// Create/set/cancel, stats and query scan every slot; a tick scans the slots and fires
// due ones, up to MAX_FIRES_PER_TICK; handle zero and unknown ops answer without a scan.
// One item at a time: start is taken only in idle, while busy is low.
// Each result is one strobed beat; the receiver cannot stall.
// Reset: synchronous active low; clears time, fire count and all slot valid bits.
module alarm_table_scheduler #(
    parameter int SLOTS = 16,
    parameter int MAX_FIRES_PER_TICK = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ats_pkg::t_item i_item,
    output logic          busy,
    output logic          o_valid,
    output ats_pkg::t_res o_res
);
    import ats_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] handler;
        logic [63:0] due;
        logic [62:0] period;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EVAL = 6'b000100,
        S_CHK  = 6'b001000,
        S_FIRE = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state         r_state;
    t_entry         r_mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    t_entry         r_rd;
    logic           r_rd_v;
    logic           mem_we;
    logic           mem_re;
    logic [IW-1:0]  mem_wa;
    t_entry         mem_wd;

    logic [2:0]     r_op;
    logic [31:0]    r_handle;
    logic [31:0]    r_hd;
    logic [63:0]    r_amount;
    logic [62:0]    r_rp;
    logic [63:0]    r_time;
    logic [31:0]    r_fcnt;
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  r_midx;
    logic [IW-1:0]  r_fidx;
    logic           r_match;
    logic           r_free;
    logic           r_found;
    logic [NW-1:0]  r_n;
    logic [ACW-1:0] r_act;
    logic [67:0]    r_lo;
    logic [67:0]    r_hi;
    t_entry         r_cur;
    t_res           r_pend;
    logic           r_pend_v;

    t_entry         ent;
    logic           e_act;
    logic           c_act;
    logic           c_due;
    logic           n_ok;
    logic           last_idx;
    logic [67:0]    p10;
    logic           q_hit;
    logic           have_sel;
    logic [IW-1:0]  sel_idx;
    logic           go_scan;
    logic           n_valid;
    t_res           n_res;
    t_res           n_pend;
    t_entry         n_cur;

    assign busy     = (r_state != S_IDLE);
    assign ent      = r_rd_v ? r_rd : '0;
    assign e_act    = (ent.handle != 32'd0) && (ent.handler != 32'd0);
    assign c_act    = (r_cur.handle != 32'd0) && (r_cur.handler != 32'd0);
    assign c_due    = (r_time >= r_cur.due);
    assign n_ok     = (r_n < NW'(MAX_FIRES_PER_TICK));
    assign last_idx = (r_idx == IW'(SLOTS - 1));
    assign p10      = ({5'd0, ent.period} << 3) + ({5'd0, ent.period} << 1);
    assign q_hit    = e_act && (ent.period != 63'd0) && (p10 >= r_lo) && (p10 <= r_hi);
    assign have_sel = r_match || r_free;
    assign sel_idx  = r_match ? r_midx : r_fidx;
    assign go_scan  = ((i_item.op <= OP_CANCEL) && (i_item.handle != 32'd0)) ||
                      (i_item.op == OP_TICK) || (i_item.op == OP_STATS) ||
                      (i_item.op == OP_QUERY);

    always_comb begin
        mem_re = (r_state == S_READ);
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = r_cur;
        if (r_state == S_CHK) begin
            mem_we = !(c_act && c_due && n_ok);
        end else if (r_state == S_FIN && r_op <= OP_CANCEL) begin
            mem_wa = sel_idx;
            case (r_op)
                OP_CREATE: begin
                    mem_we = have_sel;
                    mem_wd = '0;
                    mem_wd.handle = r_match ? r_handle : 32'd0;
                end
                OP_CANCEL: begin
                    mem_we = r_match;
                    mem_wd = '0;
                    mem_wd.due = r_cur.due;
                end
                default: begin
                    mem_we = have_sel;
                    mem_wd.handle = r_handle;
                    mem_wd.handler = r_hd;
                    mem_wd.due = r_time + r_amount;
                    mem_wd.period = (r_op == OP_SET_PER) ? r_rp : 63'd0;
                end
            endcase
        end
    end

    always_comb begin
        n_valid = ((r_state == S_IDLE) && start && !go_scan) ||
                  ((r_state == S_FIRE) && r_pend_v) || (r_state == S_FIN);
        n_res = '0;
        n_res.last = 1'b1;
        if (r_state == S_FIRE) begin
            n_res = r_pend;
        end else if (r_state != S_FIN) begin
            n_res.kind = K_NONE;
        end else if (r_op == OP_TICK) begin
            if (r_pend_v) begin
                n_res = r_pend;
                n_res.last = 1'b1;
            end else begin
                n_res.kind = K_TICK_IDLE;
            end
        end else if (r_op == OP_STATS) begin
            n_res.kind         = K_STATS;
            n_res.active_count = (r_act > ACW'(31)) ? 5'd31 : r_act[4:0];
            n_res.fire_total   = r_fcnt;
        end else if (r_op == OP_QUERY) begin
            if (r_found) begin
                n_res.kind     = K_FOUND;
                n_res.slot     = 4'(r_midx);
                n_res.deadline = r_cur.due;
            end else begin
                n_res.kind = K_NONE;
            end
        end else begin
            if (!have_sel) begin
                n_res.kind = K_FULL;
            end else if (r_op == OP_CANCEL && !r_match) begin
                n_res.kind = K_NONE;
            end else begin
                n_res.kind = K_ACCEPTED;
                n_res.slot = 4'(sel_idx);
            end
        end

        n_pend               = '0;
        n_pend.kind          = K_FIRED;
        n_pend.slot          = 4'(r_idx);
        n_pend.fired_handle  = r_cur.handle;
        n_pend.fired_handler = r_cur.handler;
        n_pend.lateness      = r_time - r_cur.due;
        n_pend.fire_total    = r_fcnt + 32'd1;

        n_cur = r_cur;
        if (r_cur.period == 63'd0) begin
            n_cur.handle  = 32'd0;
            n_cur.handler = 32'd0;
        end else begin
            n_cur.due = r_cur.due + {1'b0, r_cur.period};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd   <= r_mem[r_idx];
            r_rd_v <= r_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= '0;
            o_valid  <= 1'b0;
            r_time   <= 64'd0;
            r_fcnt   <= 32'd0;
            r_pend_v <= 1'b0;
        end else begin
            o_valid <= n_valid;
            o_res   <= n_res;
            if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_item.op;
                        r_handle <= i_item.handle;
                        r_hd     <= i_item.handler_id;
                        r_amount <= i_item.amount;
                        r_rp     <= i_item.repeat_period;
                        r_idx    <= '0;
                        r_n      <= '0;
                        r_act    <= '0;
                        r_match  <= 1'b0;
                        r_free   <= 1'b0;
                        r_found  <= 1'b0;
                        r_pend_v <= 1'b0;
                        r_lo     <= ({4'd0, i_item.amount} << 3) + {4'd0, i_item.amount};
                        r_hi     <= ({4'd0, i_item.amount} << 3) +
                                    ({4'd0, i_item.amount} << 1) + {4'd0, i_item.amount};
                        if (i_item.op == OP_TICK) begin
                            r_time <= i_item.amount;
                        end
                        if (go_scan) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_op == OP_TICK) begin
                        r_cur   <= ent;
                        r_state <= S_CHK;
                    end else begin
                        if (r_op == OP_STATS) begin
                            if (e_act) begin
                                r_act <= r_act + ACW'(1);
                            end
                        end else if (r_op == OP_QUERY) begin
                            if (q_hit && !r_found) begin
                                r_found <= 1'b1;
                                r_midx  <= r_idx;
                                r_cur   <= ent;
                            end
                        end else begin
                            if (ent.handle == r_handle && !r_match) begin
                                r_match <= 1'b1;
                                r_midx  <= r_idx;
                                r_cur   <= ent;
                            end else if (ent.handle == 32'd0 && !r_free) begin
                                r_free <= 1'b1;
                                r_fidx <= r_idx;
                            end
                        end
                        if (last_idx) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= IW'(r_idx + 1'b1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_CHK: begin
                    if (c_act && c_due && n_ok) begin
                        r_state <= S_FIRE;
                    end else if (!n_ok || last_idx) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= IW'(r_idx + 1'b1);
                        r_state <= S_READ;
                    end
                end
                S_FIRE: begin
                    r_fcnt   <= r_fcnt + 32'd1;
                    r_n      <= r_n + NW'(1);
                    r_pend   <= n_pend;
                    r_pend_v <= 1'b1;
                    r_cur    <= n_cur;
                    r_state  <= S_CHK;
                end
                S_FIN: begin
                    r_state  <= S_IDLE;
                    r_pend_v <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "alarm_table_scheduler_assert.svh"

    `ATS_CHECK(a_fire_active, o_valid && o_res.kind == K_FIRED,
        o_res.fired_handle != 32'd0 && o_res.fired_handler != 32'd0)
    `ATS_CHECK(a_fire_cap, r_state == S_FIRE, r_n < NW'(MAX_FIRES_PER_TICK))
    `ATS_CHECK(a_done_last, !busy && $past(busy), o_valid && o_res.last)
    `ATS_CHECK_NEXT(a_fire_next, r_state == S_FIRE, r_state == S_CHK && r_pend_v)

endmodule
